/* rtl/sfu_pkg.sv */
// shared types and constants for the serial frame unwrapper with fcs-16
// no dependencies

package sfu_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  ESC_BYTE = 8'h7D;
    localparam logic [7:0]  ESC_XOR  = 8'h20;
    localparam logic [7:0]  BOF_BYTE = 8'hC0;
    localparam logic [7:0]  EOF_BYTE = 8'hC1;

    localparam logic [7:0]  PROTO_RESET = 8'h11;
    localparam logic [7:0]  TYPE_RESET  = 8'h01;

    // header is four bytes, data index saturates there
    localparam logic [2:0]  HDR_BYTES = 3'd4;

    typedef enum logic [0:0] {
        CFG_PROTO_ID     = 1'b0,
        CFG_MESSAGE_TYPE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FCS_ERR   = 3'd1,
        ST_BAD_PROTO = 3'd2,
        ST_BAD_TYPE  = 3'd3,
        ST_SHORT     = 3'd4
    } t_status;

    typedef struct packed {
        logic       go;
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_step;

    typedef struct packed {
        logic [7:0] proto_id;
        logic [7:0] message_type;
    } t_cfg;

    typedef struct packed {
        logic        has_result;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        t_status     status;
        logic [15:0] length_field;
    } t_result;

endpackage

/* rtl/sfu_in_if.sv */
// input channel: one raw received byte per transaction
// no dependencies

interface sfu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

/* rtl/sfu_out_if.sv */
// output channel: payload byte and/or frame close per transaction
// no dependencies

interface sfu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [2:0]  status;
    logic [15:0] length_field;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_done, output status, output length_field, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_done, input status, input length_field, output ready);
endinterface

/* rtl/sfu_crc16.sv */
// one byte step of the reflected crc-16, poly 0x8408
// depends on sfu_pkg

module sfu_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ sfu_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* rtl/sfu_core.sv */
// frame state: unescape, fcs hold, crc, header capture and frame close
// depends on sfu_pkg and sfu_crc16

module sfu_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfu_pkg::t_step   i_step,
    input  sfu_pkg::t_cfg    i_cfg,
    output sfu_pkg::t_result o_result
);

    logic        r_esc;
    logic        r_start;
    logic [7:0]  r_hold [2];
    logic [1:0]  r_hold_cnt;
    logic [15:0] r_crc;
    logic [2:0]  r_idx;
    logic [7:0]  r_hdr_proto;
    logic [7:0]  r_hdr_type;
    logic [15:0] r_hdr_len;

    logic        n_esc;
    logic [7:0]  n_hold [2];
    logic [1:0]  n_hold_cnt;
    logic [15:0] n_crc;
    logic [2:0]  n_idx;
    logic [7:0]  n_hdr_proto;
    logic [7:0]  n_hdr_type;
    logic [15:0] n_hdr_len;

    logic        have_data;
    logic [7:0]  data;
    logic        shift;
    logic [7:0]  out_byte;
    logic [15:0] crc_step;
    logic [15:0] fcs;

    assign out_byte = r_hold[0];

    sfu_crc16 u_crc (
        .i_crc  (r_crc),
        .i_byte (out_byte),
        .o_crc  (crc_step)
    );

    always_comb begin
        // unescape and flag removal
        have_data = 1'b0;
        data      = i_step.rx_byte;
        n_esc     = r_esc;
        if (r_esc) begin
            n_esc     = 1'b0;
            data      = i_step.rx_byte ^ sfu_pkg::ESC_XOR;
            have_data = 1'b1;
        end else if (i_step.rx_byte == sfu_pkg::ESC_BYTE) begin
            n_esc = !i_step.last_byte;
        end else if (r_start && i_step.rx_byte == sfu_pkg::BOF_BYTE) begin
            have_data = 1'b0;
        end else if (i_step.last_byte && i_step.rx_byte == sfu_pkg::EOF_BYTE) begin
            have_data = 1'b0;
        end else begin
            have_data = 1'b1;
        end

        // two-byte fcs hold
        shift      = have_data && (r_hold_cnt == 2'd2);
        n_hold     = r_hold;
        n_hold_cnt = r_hold_cnt;
        if (have_data && !shift) begin
            n_hold[r_hold_cnt[0]] = data;
            n_hold_cnt            = r_hold_cnt + 2'd1;
        end else if (shift) begin
            n_hold[0] = r_hold[1];
            n_hold[1] = data;
        end

        n_crc       = shift ? crc_step : r_crc;
        n_idx       = r_idx;
        n_hdr_proto = r_hdr_proto;
        n_hdr_type  = r_hdr_type;
        n_hdr_len   = r_hdr_len;
        o_result    = '0;
        if (shift) begin
            case (r_idx)
                3'd0:    n_hdr_proto     = out_byte;
                3'd1:    n_hdr_type      = out_byte;
                3'd2:    n_hdr_len[15:8] = out_byte;
                3'd3:    n_hdr_len[7:0]  = out_byte;
                default: begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_byte  = out_byte;
                end
            endcase
            if (r_idx < sfu_pkg::HDR_BYTES) begin
                n_idx = r_idx + 3'd1;
            end
        end

        // frame close
        fcs = ~n_crc;
        o_result.status = sfu_pkg::ST_OK;
        if (i_step.last_byte) begin
            o_result.frame_done = 1'b1;
            if (n_idx < sfu_pkg::HDR_BYTES) begin
                o_result.status = sfu_pkg::ST_SHORT;
            end else if (fcs[7:0] != n_hold[0] || fcs[15:8] != n_hold[1]) begin
                o_result.status = sfu_pkg::ST_FCS_ERR;
            end else begin
                o_result.length_field = n_hdr_len;
                if (n_hdr_proto != i_cfg.proto_id) begin
                    o_result.status = sfu_pkg::ST_BAD_PROTO;
                end else if (n_hdr_type != i_cfg.message_type) begin
                    o_result.status = sfu_pkg::ST_BAD_TYPE;
                end
            end
        end
        o_result.has_result = o_result.payload_valid || i_step.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= 1'b0;
            r_start    <= 1'b1;
            r_hold_cnt <= '0;
            r_crc      <= sfu_pkg::CRC_INIT;
            r_idx      <= '0;
        end else if (i_step.go) begin
            if (i_step.last_byte) begin
                r_esc      <= 1'b0;
                r_start    <= 1'b1;
                r_hold_cnt <= '0;
                r_crc      <= sfu_pkg::CRC_INIT;
                r_idx      <= '0;
            end else begin
                r_esc      <= n_esc;
                r_start    <= 1'b0;
                r_hold_cnt <= n_hold_cnt;
                r_crc      <= n_crc;
                r_idx      <= n_idx;
            end
        end
    end

    // hold and header bytes are always written before they are read
    always_ff @(posedge i_clk) begin
        if (i_step.go) begin
            r_hold      <= n_hold;
            r_hdr_proto <= n_hdr_proto;
            r_hdr_type  <= n_hdr_type;
            r_hdr_len   <= n_hdr_len;
        end
    end

endmodule

/* rtl/serial_frame_unwrapper_fcs16.sv */
// Serial frame unwrapper with FCS-16 check. Takes one raw byte of an escaped frame per
// transaction, the last byte flagged. A leading 0xC0, a trailing unescaped 0xC1 and a
// dangling 0x7D are dropped; 0x7D escapes are undone by XOR 0x20. Unescaped bytes pass a
// two-byte hold that keeps back the FCS; bytes leaving the hold feed the reflected CRC-16
// (poly 0x8408, init 0xFFFF). The first four are the header (protocol id, message type,
// big-endian length), later ones come out as payload. The last byte closes the frame with
// a status: ok, fcs mismatch, bad protocol, bad type, or short frame (fewer than six data
// bytes). A payload byte and the close may share one output transaction; bytes that give
// neither produce no output. Rate: one byte per clock while the output is not stalled.
// A byte passes an input register, then the frame logic into the result register; the
// longest path is the eight-step CRC byte update plus the FCS compare. Protocol id and
// message type registers (reset 0x11 and 0x01) are to be written by the user only while
// no frame is in flight; the block itself does not enforce this.
// depends on sfu_pkg, sfu_in_if, sfu_out_if, sfu_core, sfu_crc16

module serial_frame_unwrapper_fcs16 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfu_in_if.sink          i_rx,
    sfu_out_if.source       o_res,
    input  logic            i_cfg_we,
    input  logic [0:0]      i_cfg_idx,
    input  logic [7:0]      i_cfg_data
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic              r_out_vld;
    sfu_pkg::t_result  r_out;

    sfu_pkg::t_cfg     r_cfg;
    sfu_pkg::t_step    step;
    sfu_pkg::t_result  result;

    logic proc_go;

    // the held byte moves on when the result register is free or drains this cycle
    assign proc_go  = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || proc_go;

    assign step.go        = proc_go;
    assign step.rx_byte   = r_in_byte;
    assign step.last_byte = r_in_last;

    sfu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.proto_id     <= sfu_pkg::PROTO_RESET;
            r_cfg.message_type <= sfu_pkg::TYPE_RESET;
        end else if (i_cfg_we) begin
            case (sfu_pkg::t_cfg_idx'(i_cfg_idx))
                sfu_pkg::CFG_PROTO_ID:     r_cfg.proto_id     <= i_cfg_data;
                sfu_pkg::CFG_MESSAGE_TYPE: r_cfg.message_type <= i_cfg_data;
                default:                   r_cfg              <= r_cfg;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_last <= i_rx.last_byte;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_go) begin
            r_out_vld <= result.has_result;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && result.has_result) begin
            r_out <= result;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.payload_valid = r_out.payload_valid;
    assign o_res.frame_done    = r_out.frame_done;
    assign o_res.status        = r_out.status;
    assign o_res.length_field  = r_out.length_field;

endmodule
